### sv/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define RSTF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rstf assertion failed");

// next-cycle implication, disabled during reset
`define RSTF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rstf assertion failed");

`endif

### sv/rstf_pkg.sv
// constants, types and the character decoder of the radix numeral parser
// no dependencies
package rstf_pkg;

    localparam int CHAR_W     = 8;
    localparam int RADIX_W    = 6;
    localparam int DIG_W      = 6;
    localparam int FRAC_Q     = 48;
    localparam int PF_W       = FRAC_Q + 1;
    localparam int FRAC_SUM_W = FRAC_Q + DIG_W + 1;
    localparam int MUL_STEPS  = DIG_W;
    localparam int DIV_BITS   = 7;
    localparam int DIV_STEPS  = PF_W / DIV_BITS;
    localparam int DATA_W     = 32;
    localparam int ADDR_W     = 3;

    localparam logic [ADDR_W-1:0]  RADIX_ADDR = 3'd0;
    localparam logic [RADIX_W-1:0] RADIX_RST  = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN  = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX  = 6'd36;

    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] LETTER_BASE = 8'd10;

    typedef struct packed {
        logic             ok;
        logic [DIG_W-1:0] val;
    } t_digit;

    // digit value of an ascii character, ok low for anything else
    function automatic t_digit digit_of(input logic [CHAR_W-1:0] ch);
        t_digit d;
        d.ok  = 1'b0;
        d.val = '0;
        if (ch >= CH_0 && ch <= CH_9) begin
            d.ok  = 1'b1;
            d.val = DIG_W'(ch - CH_0);
        end else if (ch >= CH_UA && ch <= CH_UZ) begin
            d.ok  = 1'b1;
            d.val = DIG_W'(ch - CH_UA + LETTER_BASE);
        end else if (ch >= CH_LA && ch <= CH_LZ) begin
            d.ok  = 1'b1;
            d.val = DIG_W'(ch - CH_LA + LETTER_BASE);
        end
        return d;
    endfunction

endpackage

### sv/rstf_in_if.sv
// character input channel: valid/ready handshake with one character per item
// depends on rstf_pkg
interface rstf_in_if;
    logic                       valid;
    logic                       ready;
    logic [rstf_pkg::CHAR_W-1:0] char_code;
    logic                       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

### sv/rstf_out_if.sv
// result output channel: valid/ready handshake with one parsed value per item
// no dependencies
interface rstf_out_if #(
    parameter int INT_BITS      = 52,
    parameter int FRAC_OUT_BITS = 32
);
    logic                     valid;
    logic                     ready;
    logic                     negative;
    logic [INT_BITS-1:0]      integer_part;
    logic [FRAC_OUT_BITS-1:0] fraction_part;
    logic                     saturated;

    modport source (output valid, output negative, output integer_part,
                    output fraction_part, output saturated, input ready);
    modport sink   (input valid, input negative, input integer_part,
                    input fraction_part, input saturated, output ready);
endinterface

### sv/rstf_div.sv
// iterative divider of the place factor by the radix, several quotient bits per cycle
// depends on rstf_pkg
module rstf_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rstf_pkg::PF_W-1:0]     i_dividend,
    input  logic [rstf_pkg::RADIX_W-1:0]  i_divisor,
    output logic [rstf_pkg::PF_W-1:0]     o_quotient,
    output logic                          o_done
);
    localparam int PF_W  = rstf_pkg::PF_W;
    localparam int RW    = rstf_pkg::RADIX_W;
    localparam int DB    = rstf_pkg::DIV_BITS;
    localparam int CNT_W = $clog2(rstf_pkg::DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(rstf_pkg::DIV_STEPS - 1);

    logic [PF_W-1:0]  r_num;
    logic [RW-1:0]    r_rem;
    logic [RW-1:0]    r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [RW-1:0]    n_rem;
    logic [DB-1:0]    n_qbits;

    // restoring division of the top bits, remainder stays below the divisor
    always_comb begin
        logic [RW:0] rem;
        rem     = {1'b0, r_rem};
        n_qbits = '0;
        for (int i = 0; i < DB; i++) begin
            rem = {rem[RW-1:0], r_num[PF_W-1-i]};
            if (rem >= {1'b0, r_div}) begin
                rem              = rem - {1'b0, r_div};
                n_qbits[DB-1-i]  = 1'b1;
            end
        end
        n_rem = rem[RW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_LAST);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_num <= {r_num[PF_W-DB-1:0], n_qbits};
            r_rem <= n_rem;
        end
    end

    assign o_quotient = r_num;
    assign o_done     = r_done;
endmodule

### sv/rstf_mac.sv
// shared shift-add multiply-accumulate: sum = addend + x * m, one bit of m per cycle
// depends on rstf_pkg
module rstf_mac #(
    parameter int W = 59
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [W-1:0]                i_x,
    input  logic [rstf_pkg::DIG_W-1:0]  i_m,
    input  logic [W-1:0]                i_addend,
    output logic [W-1:0]                o_sum,
    output logic                        o_done
);
    localparam int MW    = rstf_pkg::DIG_W;
    localparam int CNT_W = $clog2(rstf_pkg::MUL_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(rstf_pkg::MUL_STEPS - 1);

    logic [W-1:0]     r_sum;
    logic [W-1:0]     r_x;
    logic [MW-1:0]    r_m;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_LAST);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sum <= i_addend;
            r_x   <= i_x;
            r_m   <= i_m;
        end else if (r_busy) begin
            if (r_m[0]) begin
                r_sum <= r_sum + r_x;
            end
            r_x <= {r_x[W-2:0], 1'b0};
            r_m <= {1'b0, r_m[MW-1:1]};
        end
    end

    assign o_sum  = r_sum;
    assign o_done = r_done;
endmodule

### sv/radix_string_to_fixed_top.sv
// radix numeral parser: characters in, sign / saturated integer / q0.32 fraction out
// integer digit: the 6-step shift-add unit, then a finish state, before the next accept
// fraction digit: the 7-step place-factor divider, then the shift-add unit, then a finish state
// other characters: finish state only; the result loads from the last one once the output is free
// synchronous active-low reset: radix 10, numeral state cleared, no result pending
module radix_string_to_fixed_top #(
    parameter int INT_BITS      = 52,
    parameter int FRAC_OUT_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    rstf_in_if.sink                         i_in,
    rstf_out_if.source                      o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rstf_pkg::ADDR_W-1:0]     paddr,
    input  logic [rstf_pkg::DATA_W-1:0]     pwdata,
    output logic [rstf_pkg::DATA_W-1:0]     prdata,
    output logic                            pready
);
    localparam int RW     = rstf_pkg::RADIX_W;
    localparam int DW     = rstf_pkg::DIG_W;
    localparam int FQ     = rstf_pkg::FRAC_Q;
    localparam int PF_W   = rstf_pkg::PF_W;
    // shared adder width covers acc*radix+digit and frac+digit*factor
    localparam int MAC_W  = (INT_BITS + RW + 1 > rstf_pkg::FRAC_SUM_W) ?
                            (INT_BITS + RW + 1) : rstf_pkg::FRAC_SUM_W;
    localparam logic [INT_BITS-1:0] IMAX = '1;
    localparam logic [PF_W-1:0] PF_ONE = {1'b1, {FQ{1'b0}}};

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_MAC  = 4'b0100,
        ST_FIN  = 4'b1000
    } t_state;

    // numeral phase: integer digits, fraction digits, stopped
    typedef enum logic [1:0] {
        PH_INT  = 2'd0,
        PH_FRAC = 2'd1,
        PH_STOP = 2'd2
    } t_phase;

    t_state               r_state;
    t_phase               r_phase;
    logic                 r_first;
    logic                 r_sign;
    logic [INT_BITS-1:0]  r_int_acc;
    logic                 r_ovf;
    logic [PF_W-1:0]      r_pf;
    logic [FQ-1:0]        r_frac_acc;
    logic                 r_last;
    logic [DW-1:0]        r_digit;
    logic [RW-1:0]        r_radix;

    // result register, parts the output side from the sequencer
    logic                     r_out_valid;
    logic                     r_out_neg;
    logic [INT_BITS-1:0]      r_out_int;
    logic [FRAC_OUT_BITS-1:0] r_out_frac;
    logic                     r_out_sat;

    logic                 in_acc;
    logic                 radix_ok;
    logic                 active;
    logic                 is_sign;
    rstf_pkg::t_digit     dig;
    logic                 dig_ok;
    logic                 take_digit;
    logic                 int_go;
    logic                 frac_go;
    logic                 out_free;
    logic                 out_load;
    logic                 cfg_wr;

    logic                 div_done;
    logic [PF_W-1:0]      div_q;
    logic                 mac_start;
    logic [MAC_W-1:0]     mac_x;
    logic [DW-1:0]        mac_m;
    logic [MAC_W-1:0]     mac_addend;
    logic [MAC_W-1:0]     mac_sum;
    logic                 mac_done;

    // accept decode, all from the current character and numeral state
    assign in_acc     = i_in.valid && i_in.ready;
    assign radix_ok   = (r_radix >= rstf_pkg::RADIX_MIN) && (r_radix <= rstf_pkg::RADIX_MAX);
    assign active     = (r_phase == PH_INT) || (r_phase == PH_FRAC);
    assign is_sign    = r_first && (i_in.char_code == rstf_pkg::CH_MINUS);
    assign dig        = rstf_pkg::digit_of(i_in.char_code);
    assign dig_ok     = dig.ok && (dig.val < r_radix);
    assign take_digit = active && radix_ok && !is_sign && dig_ok;
    assign int_go     = in_acc && take_digit && (r_phase == PH_INT);
    assign frac_go    = in_acc && take_digit && (r_phase == PH_FRAC);

    assign out_free   = !r_out_valid || o_out.ready;
    assign out_load   = (r_state == ST_FIN) && r_last && out_free;
    assign cfg_wr     = psel && penable && pwrite && pready;

    // integer digits start the shared unit right away,
    // fraction digits start it once the factor has been divided
    assign mac_start  = int_go || ((r_state == ST_DIV) && div_done);
    always_comb begin
        if (r_state == ST_DIV) begin
            mac_x      = MAC_W'(div_q);
            mac_m      = r_digit;
            mac_addend = MAC_W'(r_frac_acc);
        end else begin
            mac_x      = MAC_W'(r_int_acc);
            mac_m      = r_radix;
            mac_addend = MAC_W'(dig.val);
        end
    end

    rstf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (frac_go),
        .i_dividend (r_pf),
        .i_divisor  (r_radix),
        .o_quotient (div_q),
        .o_done     (div_done)
    );

    rstf_mac #(
        .W (MAC_W)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mac_start),
        .i_x      (mac_x),
        .i_m      (mac_m),
        .i_addend (mac_addend),
        .o_sum    (mac_sum),
        .o_done   (mac_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_INT;
            r_first     <= 1'b1;
            r_sign      <= 1'b0;
            r_int_acc   <= '0;
            r_ovf       <= 1'b0;
            r_pf        <= PF_ONE;
            r_frac_acc  <= '0;
            r_last      <= 1'b0;
            r_digit     <= '0;
            r_radix     <= rstf_pkg::RADIX_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr && (paddr == rstf_pkg::RADIX_ADDR)) begin
                r_radix <= pwdata[RW-1:0];
            end
            // offered until taken, a new result loads once the slot is free
            r_out_valid <= out_load || (r_out_valid && !o_out.ready);

            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_last  <= i_in.last_char;
                        r_first <= 1'b0;
                        r_digit <= dig.val;
                        if (active) begin
                            if (!radix_ok) begin
                                r_phase <= PH_STOP;
                            end else if (is_sign) begin
                                r_sign <= 1'b1;
                            end else if (dig_ok) begin
                                // arithmetic follows in the units
                            end else if (i_in.char_code == rstf_pkg::CH_DOT &&
                                         r_phase == PH_INT) begin
                                r_phase <= PH_FRAC;
                            end else begin
                                r_phase <= PH_STOP;
                            end
                        end
                        if (int_go) begin
                            r_state <= ST_MAC;
                        end else if (frac_go) begin
                            r_state <= ST_DIV;
                        end else begin
                            r_state <= ST_FIN;
                        end
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_pf    <= div_q;
                        r_state <= ST_MAC;
                    end
                end
                ST_MAC: begin
                    if (mac_done) begin
                        if (r_phase == PH_INT) begin
                            // anything above the integer width means overflow
                            if (|mac_sum[MAC_W-1:INT_BITS]) begin
                                r_int_acc <= IMAX;
                                r_ovf     <= 1'b1;
                            end else begin
                                r_int_acc <= mac_sum[INT_BITS-1:0];
                            end
                        end else begin
                            r_frac_acc <= mac_sum[FQ-1:0];
                        end
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (!r_last) begin
                        r_state <= ST_IDLE;
                    end else if (out_free) begin
                        // result handed over, start a new numeral
                        r_phase     <= PH_INT;
                        r_first     <= 1'b1;
                        r_sign      <= 1'b0;
                        r_int_acc   <= '0;
                        r_ovf       <= 1'b0;
                        r_pf        <= PF_ONE;
                        r_frac_acc  <= '0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // result payload, zero for an unsupported radix
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            if (radix_ok) begin
                r_out_neg  <= r_sign;
                r_out_int  <= r_int_acc;
                r_out_frac <= r_frac_acc[FQ-1 -: FRAC_OUT_BITS];
                r_out_sat  <= r_ovf;
            end else begin
                r_out_neg  <= 1'b0;
                r_out_int  <= '0;
                r_out_frac <= '0;
                r_out_sat  <= 1'b0;
            end
        end
    end

    assign i_in.ready          = (r_state == ST_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.negative      = r_out_neg;
    assign o_out.integer_part  = r_out_int;
    assign o_out.fraction_part = r_out_frac;
    assign o_out.saturated     = r_out_sat;

    // register file: radix only
    assign pready = 1'b1;
    assign prdata = (paddr == rstf_pkg::RADIX_ADDR) ?
                    {{(rstf_pkg::DATA_W - RW){1'b0}}, r_radix} : '0;
endmodule

### sv/rstf_checker.sv
// port-level checks of the radix numeral parser, bound to the top level
// depends on assert_macros.svh and radix_string_to_fixed_top
`include "assert_macros.svh"

module rstf_checker #(
    parameter int INT_BITS = 52
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic                i_out_saturated,
    input logic [INT_BITS-1:0] i_out_integer_part
);
    localparam logic [INT_BITS-1:0] IMAX = '1;

    // a waiting result stays offered
    `RSTF_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    // each accepted character drops ready, as the parser leaves its idle state
    `RSTF_ASSERT_NXT(a_busy_after_item, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

    // a saturated result carries the largest integer
    `RSTF_ASSERT_IMP(a_sat_max, i_clk, i_rst_n, i_out_valid && i_out_saturated, i_out_integer_part == IMAX)
endmodule

bind radix_string_to_fixed_top rstf_checker #(
    .INT_BITS (INT_BITS)
) u_rstf_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in.valid),
    .i_in_ready         (i_in.ready),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_out_saturated    (o_out.saturated),
    .i_out_integer_part (o_out.integer_part)
);

### test/radix_string_to_fixed_top_tb.sv
// self-checking bench for radix_string_to_fixed_top: numerals in, parsed values compared
// depends on rstf_pkg, rstf_in_if, rstf_out_if and the top level of the parser
`timescale 1ns / 1ps

typedef struct packed {
    logic        negative;
    logic [51:0] integer_part;
    logic [31:0] fraction_part;
    logic        saturated;
} t_parsed_value;

// follows the parser one character at a time and holds the values still owed
class numeral_board;
    localparam int INT_W  = 52;
    localparam int FRAC_W = 32;
    localparam int CHAR_W = rstf_pkg::CHAR_W;
    localparam int PF_W   = rstf_pkg::PF_W;
    localparam int FRAC_Q = rstf_pkg::FRAC_Q;
    localparam longint unsigned INT_MAX = (64'd1 << INT_W) - 64'd1;

    typedef longint unsigned t_u64;
    typedef enum {SCAN_INT, SCAN_FRAC, SCAN_STOP} t_scan;

    int unsigned     radix;
    t_scan           scan;
    bit              at_first;
    bit              minus_seen;
    bit              sat;
    longint unsigned int_acc;
    logic [PF_W-1:0] place;
    logic [FRAC_Q-1:0] frac_acc;
    t_parsed_value   pending[$];
    int              errors;

    function new();
        radix  = int'(rstf_pkg::RADIX_RST);
        errors = 0;
        start_numeral();
    endfunction

    function void start_numeral();
        scan       = SCAN_INT;
        at_first   = 1'b1;
        minus_seen = 1'b0;
        sat        = 1'b0;
        int_acc    = 0;
        place      = PF_W'(1) << FRAC_Q;
        frac_acc   = '0;
    endfunction

    function int char_digit(logic [CHAR_W-1:0] ch);
        if (ch >= rstf_pkg::CH_0 && ch <= rstf_pkg::CH_9) return int'(ch - rstf_pkg::CH_0);
        if (ch >= rstf_pkg::CH_UA && ch <= rstf_pkg::CH_UZ)
            return int'(ch - rstf_pkg::CH_UA) + 10;
        if (ch >= rstf_pkg::CH_LA && ch <= rstf_pkg::CH_LZ)
            return int'(ch - rstf_pkg::CH_LA) + 10;
        return -1;
    endfunction

    // one accepted character; a value is owed when it closes the numeral
    function void note_char(logic [CHAR_W-1:0] ch, logic last);
        int              d;
        bit              base_ok;
        longint unsigned n;
        longint unsigned prod;
        t_parsed_value   want;
        base_ok = radix >= rstf_pkg::RADIX_MIN && radix <= rstf_pkg::RADIX_MAX;
        if (scan != SCAN_STOP) begin
            d = char_digit(ch);
            if (!base_ok) begin
                scan = SCAN_STOP;
            end else if (at_first && ch == rstf_pkg::CH_MINUS) begin
                minus_seen = 1'b1;
            end else if (d >= 0 && d < int'(radix)) begin
                n = t_u64'(d);
                if (scan == SCAN_INT) begin
                    if (int_acc > (INT_MAX - n) / t_u64'(radix)) begin
                        int_acc = INT_MAX;
                        sat     = 1'b1;
                    end else begin
                        int_acc = int_acc * t_u64'(radix) + n;
                    end
                end else begin
                    place    = place / PF_W'(radix);
                    prod     = n * t_u64'(place);
                    frac_acc = frac_acc + prod[FRAC_Q-1:0];
                end
            end else if (ch == rstf_pkg::CH_DOT && scan == SCAN_INT) begin
                scan = SCAN_FRAC;
            end else begin
                scan = SCAN_STOP;
            end
        end
        at_first = 1'b0;
        if (!last) return;
        want = '0;
        if (base_ok) begin
            want.negative      = minus_seen;
            want.integer_part  = int_acc[INT_W-1:0];
            want.fraction_part = frac_acc[FRAC_Q-1 -: FRAC_W];
            want.saturated     = sat;
        end
        pending.push_back(want);
        start_numeral();
    endfunction

    task report(string what);
        errors++;
        $display("mismatch: %s", what);
    endtask

    task check_result(t_parsed_value got);
        t_parsed_value want;
        if (pending.size() == 0) begin
            report($sformatf("value with none owed: neg=%0b int=%0d frac=%h sat=%0b",
                   got.negative, got.integer_part, got.fraction_part, got.saturated));
            return;
        end
        want = pending.pop_front();
        if (got.negative !== want.negative)
            report($sformatf("negative %0b, want %0b", got.negative, want.negative));
        if (got.integer_part !== want.integer_part)
            report($sformatf("integer_part %0d, want %0d", got.integer_part,
                   want.integer_part));
        if (got.fraction_part !== want.fraction_part)
            report($sformatf("fraction_part %h, want %h", got.fraction_part,
                   want.fraction_part));
        if (got.saturated !== want.saturated)
            report($sformatf("saturated %0b, want %0b", got.saturated, want.saturated));
    endtask
endclass

module radix_string_to_fixed_top_tb;
    localparam int INT_BITS      = 52;
    localparam int FRAC_OUT_BITS = 32;
    localparam int ADDR_W        = rstf_pkg::ADDR_W;
    localparam int DATA_W        = rstf_pkg::DATA_W;
    localparam int RADIX_W       = rstf_pkg::RADIX_W;
    localparam int CHAR_W        = rstf_pkg::CHAR_W;
    // settle margin covers the slowest item, a fraction digit, and the result register
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PHASES        = 11;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int unsigned send_idle_pct;
    int unsigned stall_pct;
    int unsigned phase_chars;
    int unsigned cycle_count;

    numeral_board board = new();

    rstf_in_if  in_if();
    rstf_out_if #(.INT_BITS(INT_BITS), .FRAC_OUT_BITS(FRAC_OUT_BITS)) out_if();

    radix_string_to_fixed_top #(
        .INT_BITS      (INT_BITS),
        .FRAC_OUT_BITS (FRAC_OUT_BITS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 2 ns clock
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // result side: random back-pressure at the current stall rate
    always @(posedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    // every accepted character goes through the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready)
            board.note_char(in_if.char_code, in_if.last_char);
    end

    // every accepted result is checked against the oldest value owed
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            board.check_result('{out_if.negative, out_if.integer_part,
                                 out_if.fraction_part, out_if.saturated});
    end

    // a hung handshake ends the run here
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("radix_string_to_fixed_top_tb failed");
        $finish;
    end

    // register write: setup phase, then access phase until pready
    task apb_write_radix(input logic [RADIX_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= rstf_pkg::RADIX_ADDR;
        pwdata  <= DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.radix = int'(value);
    endtask

    // one character item; random gaps before it at the current idle rate
    task send_char(input logic [CHAR_W-1:0] ch, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.char_code <= ch;
        in_if.last_char <= last;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        phase_chars++;
    endtask

    task send_text(input string s);
        for (int k = 0; k < s.len(); k++)
            send_char(s[k], k == s.len() - 1);
    endtask

    // a digit character of value v, letters in either case
    function logic [CHAR_W-1:0] digit_char(int unsigned v);
        if (v < 10) return rstf_pkg::CH_0 + CHAR_W'(v);
        return ($urandom_range(1) ? rstf_pkg::CH_LA : rstf_pkg::CH_UA) + CHAR_W'(v - 10);
    endfunction

    // mostly well-formed numerals, some broken by a stray character, some pure noise
    task send_numeral(input int unsigned base);
        logic [CHAR_W-1:0] text[$];
        int unsigned       kind;
        int unsigned       n;
        int unsigned       pos;
        kind = $urandom_range(99);
        if (kind < 90) begin
            if ($urandom_range(3) == 0) text.push_back(rstf_pkg::CH_MINUS);
            // now and then long enough to saturate even in base 2
            n = ($urandom_range(9) == 0) ? $urandom_range(64) : $urandom_range(8);
            repeat (n) text.push_back(digit_char($urandom_range(base - 1)));
            if ($urandom_range(2) != 0) begin
                text.push_back(rstf_pkg::CH_DOT);
                // long fractions run the place factor down to zero
                n = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(10);
                repeat (n) text.push_back(digit_char($urandom_range(base - 1)));
            end
            if (kind >= 75) begin
                pos = $urandom_range(text.size());
                case ($urandom_range(2))
                    0: text.insert(pos, rstf_pkg::CH_DOT);
                    1: text.insert(pos, rstf_pkg::CH_MINUS);
                    default: text.insert(pos, CHAR_W'($urandom_range(255)));
                endcase
            end
        end else begin
            repeat ($urandom_range(1, 6)) text.push_back(CHAR_W'($urandom_range(255)));
        end
        if (text.size() == 0) text.push_back(digit_char($urandom_range(base - 1)));
        foreach (text[k]) send_char(text[k], k == text.size() - 1);
    endtask

    // wait for every owed value, then for the block to go quiet
    task drain;
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int unsigned radix_plan[PHASES];
        int unsigned target;
        bit          base_ok;

        radix_plan = '{36, 2, 0, 16, 63, 0, 1, 10, 37, 8, 5};
        radix_plan[5] = $urandom_range(3, 35);

        i_rst_n         <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.char_code <= '0;
        in_if.last_char <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        phase_chars   = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed numerals at the reset radix of ten
        send_text("-1.5");
        send_text(".");             // empty numeral, dot only
        send_text("-");             // empty numeral, sign only
        send_text("7-");            // minus after the first position stops
        send_text("1.2.3");         // second dot stops
        send_text("9a5");           // digit not in the base stops
        send_char(8'hFF, 1'b1);     // invalid first character, top code
        send_char(8'h00, 1'b1);     // invalid first character, bottom code
        drain();

        for (int p = 0; p < PHASES; p++) begin
            apb_write_radix(RADIX_W'(radix_plan[p]));
            base_ok = radix_plan[p] >= rstf_pkg::RADIX_MIN &&
                      radix_plan[p] <= rstf_pkg::RADIX_MAX;
            // unsupported bases only ever give zeros, so fewer items there
            target = base_ok ? 160 : 45;
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 88; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 88; end
                default: begin send_idle_pct = 32; stall_pct = 32; end
            endcase
            phase_chars = 0;
            while (phase_chars < target)
                send_numeral(base_ok ? radix_plan[p] : 36);
            drain();
        end

        if (board.pending.size() != 0)
            board.report($sformatf("%0d values never came", board.pending.size()));
        if (board.errors == 0)
            $display("radix_string_to_fixed_top_tb passed");
        else
            $display("radix_string_to_fixed_top_tb failed");
        $finish;
    end
endmodule
